FILE: rtl/tsf_pkg.sv
// tsf_pkg: shared types, constants and edge stepping helpers for the
// scanline triangle fill block. No dependencies.
`timescale 1ns / 1ps
package tsf_pkg;

  localparam int COORD_BITS = 12;
  localparam int MAX_ROWS   = 64;
  localparam int ROW_BITS   = $clog2(MAX_ROWS + 1);
  localparam int CNT_BITS   = $clog2(COORD_BITS);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ROW_BITS-1:0]   row_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_DLG   = 7'b0000100,
    S_DLW   = 7'b0001000,
    S_DSG   = 7'b0010000,
    S_DSW   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  // one edge walked as base +/- (q0 + r0/len) per row
  typedef struct packed {
    coord_t base;
    logic   neg;
    coord_t len;
    coord_t q0;
    coord_t r0;
    coord_t acc_q;
    coord_t acc_r;
  } edge_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } tri_t;

  function automatic edge_t edge_step(edge_t e);
    logic [COORD_BITS:0] rs;
    edge_t n;
    n  = e;
    rs = {1'b0, e.acc_r} + {1'b0, e.r0};
    if (rs >= {1'b0, e.len}) begin
      n.acc_r = COORD_BITS'(rs - {1'b0, e.len});
      n.acc_q = e.acc_q + e.q0 + COORD_BITS'(1);
    end else begin
      n.acc_r = COORD_BITS'(rs);
      n.acc_q = e.acc_q + e.q0;
    end
    return n;
  endfunction

  function automatic coord_t edge_x(edge_t e);
    return e.neg ? (e.base - e.acc_q) : (e.base + e.acc_q);
  endfunction

endpackage

FILE: rtl/tsf_in_if.sv
// tsf_in_if: input channel carrying one triangle word.
// Depends on tsf_pkg.
`timescale 1ns / 1ps
interface tsf_in_if;
  logic               valid;
  logic               ready;
  tsf_pkg::coord_t    first_x;
  tsf_pkg::coord_t    first_y;
  tsf_pkg::coord_t    second_x;
  tsf_pkg::coord_t    second_y;
  tsf_pkg::coord_t    third_x;
  tsf_pkg::coord_t    third_y;
  modport source(output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                 input ready);
  modport sink(input valid, first_x, first_y, second_x, second_y, third_x, third_y,
               output ready);
endinterface

FILE: rtl/tsf_out_if.sv
// tsf_out_if: result channel carrying one span word.
// Depends on tsf_pkg.
`timescale 1ns / 1ps
interface tsf_out_if;
  logic            valid;
  logic            ready;
  tsf_pkg::coord_t row_y;
  tsf_pkg::coord_t span_left;
  tsf_pkg::coord_t span_right;
  logic            last_span;
  logic            empty_triangle;
  logic            rows_clipped;
  modport source(output valid, row_y, span_left, span_right, last_span, empty_triangle,
                 rows_clipped, input ready);
  modport sink(input valid, row_y, span_left, span_right, last_span, empty_triangle,
               rows_clipped, output ready);
endinterface

FILE: rtl/tsf_sort.sv
// tsf_sort: three compare-and-swap steps ordering vertices by y.
// Depends on tsf_pkg.
`timescale 1ns / 1ps
module tsf_sort (
  input  tsf_pkg::tri_t tri_in,
  output tsf_pkg::tri_t tri_out
);

  tsf_pkg::tri_t s1, s2, s3;

  always_comb begin
    s1 = tri_in;
    if (tri_in.y0 > tri_in.y1) begin
      s1.x0 = tri_in.x1; s1.y0 = tri_in.y1;
      s1.x1 = tri_in.x0; s1.y1 = tri_in.y0;
    end
    s2 = s1;
    if (s1.y1 > s1.y2) begin
      s2.x1 = s1.x2; s2.y1 = s1.y2;
      s2.x2 = s1.x1; s2.y2 = s1.y1;
    end
    s3 = s2;
    if (s2.y0 > s2.y1) begin
      s3.x0 = s2.x1; s3.y0 = s2.y1;
      s3.x1 = s2.x0; s3.y1 = s2.y0;
    end
  end

  assign tri_out = s3;

endmodule

FILE: rtl/tsf_div.sv
// tsf_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on tsf_pkg.
`timescale 1ns / 1ps
module tsf_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  tsf_pkg::coord_t dividend,
  input  tsf_pkg::coord_t divisor,
  output logic            done,
  output tsf_pkg::coord_t quotient,
  output tsf_pkg::coord_t remainder
);

  localparam int CB = tsf_pkg::COORD_BITS;

  tsf_pkg::coord_t quo_r, rem_r, dsr_r;
  logic [tsf_pkg::CNT_BITS-1:0] cnt_r;
  logic busy_r, done_r;
  logic [CB:0] trial;
  logic        fits;

  assign trial = {rem_r, quo_r[CB-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? CB'(trial - {1'b0, dsr_r}) : CB'(trial);
        quo_r <= {quo_r[CB-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tsf_pkg::CNT_BITS'(CB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/triangle_scanline_fill.sv
// triangle_scanline_fill: top level, sequencer, edge walkers and span register.
// Depends on tsf_pkg, tsf_in_if, tsf_out_if, tsf_sort, tsf_div.
//
//   channel   dir  words             handshake
//   in_tri    in   one triangle      valid/ready
//   out_span  out  1..64 spans       valid/ready
//
// after a triangle is taken, in_tri.ready stays low through the setup state, the
// edge division (two 12-bit divides at one bit per cycle, each with load and
// result), the span emission, and one more divide when the walk turns the middle
// vertex. a zero-height triangle keeps ready low through setup and its one word.
// reset is synchronous; a stalled out_span holds the walk in place.
`timescale 1ns / 1ps
module triangle_scanline_fill (
  input logic       clk,
  input logic       rst_n,
  tsf_in_if.sink    in_tri,
  tsf_out_if.source out_span
);

  localparam int CB = tsf_pkg::COORD_BITS;

  tsf_pkg::state_t state_r;
  tsf_pkg::tri_t   raw_tri, sorted_tri, sv_r;
  tsf_pkg::edge_t  long_r, short_r;
  tsf_pkg::coord_t total_r, upper_r;
  tsf_pkg::row_t   row_r, count_r;
  logic            empty_r, clip_r, short_lower_r;

  logic            out_valid_r, last_r, empty_o_r, clip_o_r;
  tsf_pkg::coord_t row_y_r, left_r, right_r;

  logic            div_start, div_done;
  tsf_pkg::coord_t div_num, div_den, div_quo, div_rem;

  logic [CB:0]     dl, ds;
  logic            dl_neg, ds_neg;
  tsf_pkg::coord_t dl_mag, ds_mag, s_base, s_len;
  tsf_pkg::coord_t ax, bx, total_c, upper_c;
  logic            out_free, is_last, do_switch, emit;

  assign raw_tri = '{x0: in_tri.first_x, y0: in_tri.first_y, x1: in_tri.second_x,
                     y1: in_tri.second_y, x2: in_tri.third_x, y2: in_tri.third_y};

  tsf_sort u_sort (.tri_in(raw_tri), .tri_out(sorted_tri));

  assign in_tri.ready = (state_r == tsf_pkg::S_IDLE);

  assign total_c = sv_r.y2 - sv_r.y0;
  assign upper_c = sv_r.y1 - sv_r.y0;

  // long edge and current short edge magnitudes
  always_comb begin
    dl     = {1'b0, sv_r.x2} - {1'b0, sv_r.x0};
    dl_neg = dl[CB];
    dl_mag = dl_neg ? CB'(-dl) : CB'(dl);
    if (short_lower_r) begin
      ds     = {1'b0, sv_r.x2} - {1'b0, sv_r.x1};
      s_base = sv_r.x1;
      s_len  = sv_r.y2 - sv_r.y1;
    end else begin
      ds     = {1'b0, sv_r.x1} - {1'b0, sv_r.x0};
      s_base = sv_r.x0;
      s_len  = upper_r;
    end
    ds_neg = ds[CB];
    ds_mag = ds_neg ? CB'(-ds) : CB'(ds);
  end

  assign div_start = (state_r == tsf_pkg::S_DLG) || (state_r == tsf_pkg::S_DSG);
  assign div_num   = (state_r == tsf_pkg::S_DLG) ? dl_mag : ds_mag;
  assign div_den   = (state_r == tsf_pkg::S_DLG) ? total_r : s_len;

  tsf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
    .divisor(div_den), .done(div_done), .quotient(div_quo), .remainder(div_rem)
  );

  always_comb begin
    ax = tsf_pkg::edge_x(long_r);
    bx = tsf_pkg::edge_x(short_r);
  end

  assign out_free  = !out_valid_r || out_span.ready;
  assign emit      = (state_r == tsf_pkg::S_EMIT) && out_free;
  assign is_last   = empty_r || (row_r == count_r - 1'b1);
  assign do_switch = !short_lower_r && ({{(CB-tsf_pkg::ROW_BITS){1'b0}}, row_r} == upper_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_span.ready && !emit) out_valid_r <= 1'b0;
      unique case (state_r)
        tsf_pkg::S_IDLE: begin
          if (in_tri.valid) begin
            sv_r    <= sorted_tri;
            state_r <= tsf_pkg::S_SETUP;
          end
        end
        tsf_pkg::S_SETUP: begin
          total_r       <= total_c;
          upper_r       <= upper_c;
          empty_r       <= (total_c == '0);
          clip_r        <= (total_c > CB'(tsf_pkg::MAX_ROWS));
          count_r       <= (total_c > CB'(tsf_pkg::MAX_ROWS)) ?
                           tsf_pkg::ROW_BITS'(tsf_pkg::MAX_ROWS) :
                           total_c[tsf_pkg::ROW_BITS-1:0];
          row_r         <= '0;
          short_lower_r <= (upper_c == '0);
          state_r       <= (total_c == '0) ? tsf_pkg::S_EMIT : tsf_pkg::S_DLG;
        end
        tsf_pkg::S_DLG: begin
          long_r.base <= sv_r.x0;
          long_r.neg  <= dl_neg;
          long_r.len  <= total_r;
          state_r     <= tsf_pkg::S_DLW;
        end
        tsf_pkg::S_DLW: begin
          if (div_done) begin
            long_r.q0    <= div_quo;
            long_r.r0    <= div_rem;
            long_r.acc_q <= '0;
            long_r.acc_r <= '0;
            state_r      <= tsf_pkg::S_DSG;
          end
        end
        tsf_pkg::S_DSG: begin
          short_r.base <= s_base;
          short_r.neg  <= ds_neg;
          short_r.len  <= s_len;
          state_r      <= tsf_pkg::S_DSW;
        end
        tsf_pkg::S_DSW: begin
          if (div_done) begin
            short_r.q0 <= div_quo;
            short_r.r0 <= div_rem;
            // turning the middle vertex starts the lower edge one row in
            short_r.acc_q <= (row_r == '0) ? '0 : div_quo;
            short_r.acc_r <= (row_r == '0) ? '0 : div_rem;
            state_r       <= tsf_pkg::S_EMIT;
          end
        end
        tsf_pkg::S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            row_y_r     <= sv_r.y0 + {{(CB-tsf_pkg::ROW_BITS){1'b0}}, row_r};
            left_r      <= empty_r ? '0 : ((ax > bx) ? bx : ax);
            right_r     <= empty_r ? '0 : ((ax > bx) ? ax : bx);
            last_r      <= is_last;
            empty_o_r   <= empty_r;
            clip_o_r    <= clip_r && is_last && !empty_r;
            if (is_last) begin
              state_r <= tsf_pkg::S_IDLE;
            end else begin
              row_r  <= row_r + 1'b1;
              long_r <= tsf_pkg::edge_step(long_r);
              if (do_switch) begin
                short_lower_r <= 1'b1;
                state_r       <= tsf_pkg::S_DSG;
              end else begin
                short_r <= tsf_pkg::edge_step(short_r);
              end
            end
          end
        end
        default: state_r <= tsf_pkg::S_IDLE;
      endcase
    end
  end

  assign out_span.valid          = out_valid_r;
  assign out_span.row_y          = row_y_r;
  assign out_span.span_left      = left_r;
  assign out_span.span_right     = right_r;
  assign out_span.last_span      = last_r;
  assign out_span.empty_triangle = empty_o_r;
  assign out_span.rows_clipped   = clip_o_r;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_span.valid && out_span.empty_triangle) |-> out_span.last_span)
    else $error("empty triangle word without last flag");

  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tri.valid && in_tri.ready) |=> (state_r == tsf_pkg::S_SETUP))
    else $error("accepted triangle did not enter setup");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsf_pkg::S_EMIT && !empty_r) |-> (row_r < count_r))
    else $error("row walk past row count");

endmodule
